>>> rtl/chim_pkg.sv
// Package for the chord interval matcher: field widths, operation codes,
// controller/datapath command and status structs, and small helper functions.
// No dependencies.
package chim_pkg;

	localparam int PITCH_CLASSES       = 12;
	localparam int NIBBLE_W            = 4;
	localparam int NOTE_W              = 7;
	localparam int INDEX_W             = 6;
	localparam int COUNT_W             = 4;
	localparam int PATTERN_W           = 48;
	localparam int ENTRY_W             = 1 + COUNT_W + PATTERN_W;
	localparam int DEFAULT_TABLE_DEPTH = 64;

	localparam logic OP_NOTE  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic clear_step;
		logic note_acc;
		logic write_entry;
		logic scan_init;
		logic scan_step;
		logic wrap;
		logic rot_step;
		logic search_init;
		logic search_step;
		logic out_load;
	} chim_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic empty;
		logic rot_last;
		logic hit;
		logic search_end;
		logic out_free;
	} chim_status_t;

	function automatic logic [NIBBLE_W-1:0] pitch_class(input logic [NOTE_W-1:0] note);
		logic [NOTE_W-1:0] v;
		v = note;
		if (v >= NOTE_W'(96)) v = v - NOTE_W'(96);
		if (v >= NOTE_W'(48)) v = v - NOTE_W'(48);
		if (v >= NOTE_W'(24)) v = v - NOTE_W'(24);
		if (v >= NOTE_W'(12)) v = v - NOTE_W'(12);
		return v[NIBBLE_W-1:0];
	endfunction

	function automatic logic [PATTERN_W-1:0] nibble_mask(input logic [COUNT_W-1:0] n);
		logic [PATTERN_W-1:0] m;
		m = '0;
		for (int k = 0; k < PITCH_CLASSES; k++) begin
			if (COUNT_W'(k) < n) m[k*NIBBLE_W +: NIBBLE_W] = '1;
		end
		return m;
	endfunction

endpackage

>>> rtl/chord_interval_matcher_unit.sv
// Top level of the chord interval matcher.
// Depends on chim_pkg, chim_controller and chim_datapath.
//
// Usage: the input channel (in_valid/in_stall) carries either a table write
// (operation high), which stores one chord entry at entry_index, or one chord
// note (operation low). Notes are folded into a pitch-class set; the note with
// last high starts the lookup, and exactly one result then appears on the
// output channel (out_valid/out_stall): found, match_index, interval_count
// and interval_pattern.
// A table write or a note without last does not stall the input. A note with
// last keeps the input stalled through the pitch-class scan, a wrap step, the
// rotation setup and the table search, which reads one entry per cycle from
// the single read port of the table RAM and ends early on a hit, and then
// until the result is loaded; a chord of fewer than two notes skips rotation
// and search. After reset the block runs a clearing pass over every entry of
// the table RAM, with the input stalled, before it takes its first transfer.
// A stalled output holds its result; the block keeps taking notes and writes,
// and a new lookup waits at its end until the held result has been taken.
module chord_interval_matcher_unit #(
	parameter int TABLE_DEPTH = chim_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [chim_pkg::NOTE_W-1:0]    note,
	input  logic                           last,
	input  logic [chim_pkg::INDEX_W-1:0]   entry_index,
	input  logic                           entry_valid,
	input  logic [chim_pkg::COUNT_W-1:0]   entry_count,
	input  logic [chim_pkg::PATTERN_W-1:0] entry_pattern,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [chim_pkg::INDEX_W-1:0]   match_index,
	output logic [chim_pkg::COUNT_W-1:0]   interval_count,
	output logic [chim_pkg::PATTERN_W-1:0] interval_pattern
);

	import chim_pkg::*;

	chim_cmd_t    cmd;
	chim_status_t st;

	chim_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.last     (last),
		.st       (st),
		.cmd      (cmd)
	);

	chim_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.note            (note),
		.entry_index     (entry_index),
		.entry_valid     (entry_valid),
		.entry_count     (entry_count),
		.entry_pattern   (entry_pattern),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.found           (found),
		.match_index     (match_index),
		.interval_count  (interval_count),
		.interval_pattern(interval_pattern)
	);

endmodule

>>> rtl/chim_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module chim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/chim_datapath.sv
// Datapath of the chord interval matcher: pitch-class set, interval scan,
// rotation registers, table RAM search and output register.
// Depends on chim_pkg and chim_ram.
module chim_datapath #(
	parameter int TABLE_DEPTH = chim_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  chim_pkg::chim_cmd_t              cmd,
	output chim_pkg::chim_status_t           st,
	input  logic [chim_pkg::NOTE_W-1:0]      note,
	input  logic [chim_pkg::INDEX_W-1:0]     entry_index,
	input  logic                             entry_valid,
	input  logic [chim_pkg::COUNT_W-1:0]     entry_count,
	input  logic [chim_pkg::PATTERN_W-1:0]   entry_pattern,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic                             found,
	output logic [chim_pkg::INDEX_W-1:0]     match_index,
	output logic [chim_pkg::COUNT_W-1:0]     interval_count,
	output logic [chim_pkg::PATTERN_W-1:0]   interval_pattern
);

	import chim_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int XW = 16;

	function automatic logic [PATTERN_W-1:0] set_nibble(input logic [PATTERN_W-1:0] v,
			input logic [COUNT_W-1:0] idx, input logic [NIBBLE_W-1:0] val);
		logic [PATTERN_W-1:0] r;
		r = v;
		for (int k = 0; k < PITCH_CLASSES; k++) begin
			if (idx == COUNT_W'(k)) r[k*NIBBLE_W +: NIBBLE_W] = val;
		end
		return r;
	endfunction

	function automatic logic [PATTERN_W-1:0] rotate_one(input logic [PATTERN_W-1:0] v,
			input logic [COUNT_W-1:0] n);
		logic [PATTERN_W-1:0] r;
		r = '0;
		for (int k = 0; k < PITCH_CLASSES; k++) begin
			if (COUNT_W'(k) == n - COUNT_W'(1)) begin
				r[k*NIBBLE_W +: NIBBLE_W] = v[NIBBLE_W-1:0];
			end else if (k < PITCH_CLASSES - 1) begin
				r[k*NIBBLE_W +: NIBBLE_W] = v[(k+1)*NIBBLE_W +: NIBBLE_W];
			end
		end
		return r;
	endfunction

	logic [PITCH_CLASSES-1:0] pitch_set_q;
	logic [1:0]               tally_q;
	logic [NIBBLE_W-1:0]      pc_q;
	logic [NIBBLE_W-1:0]      prev_q;
	logic                     have_prev_q;
	logic [COUNT_W-1:0]       count_q;
	logic [NIBBLE_W-1:0]      sum_q;
	logic [PATTERN_W-1:0]     seq_q;
	logic [PATTERN_W-1:0]     mask_q;
	logic [PATTERN_W-1:0]     rot_q [PITCH_CLASSES];
	logic [NIBBLE_W-1:0]      rot_cnt_q;
	logic [AW:0]              addr_q;
	logic [AW-1:0]            clr_q;
	logic                     rd_valid_s1;
	logic [AW-1:0]            rd_idx_s1;
	logic                     res_found_q;
	logic [AW-1:0]            res_idx_q;
	logic                     out_valid_q;
	logic                     found_q;
	logic [INDEX_W-1:0]       match_index_q;
	logic [COUNT_W-1:0]       interval_count_q;
	logic [PATTERN_W-1:0]     interval_pattern_q;

	logic [XW-1:0]            idx_ext;
	logic                     idx_in_range;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [ENTRY_W-1:0]       ram_wdata;
	logic                     ram_re;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic                     entry_ok;
	logic [PATTERN_W-1:0]     stored_masked;
	logic                     any_rot;
	logic                     cur_bit;
	logic [NIBBLE_W-1:0]      gap;
	logic [NIBBLE_W-1:0]      note_pc;
	logic [XW-1:0]            res_idx_ext;

	assign idx_ext      = XW'(entry_index);
	assign idx_in_range = idx_ext < XW'(TABLE_DEPTH);
	assign ram_we       = cmd.clear_step | (cmd.write_entry & idx_in_range);
	assign ram_waddr    = cmd.clear_step ? clr_q : idx_ext[AW-1:0];
	assign ram_wdata    = cmd.clear_step ? '0 : {entry_valid, entry_count, entry_pattern};
	assign ram_re       = cmd.search_step & (addr_q < (AW+1)'(TABLE_DEPTH));

	chim_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(addr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign note_pc = pitch_class(note);
	assign cur_bit = pitch_set_q[pc_q];
	assign gap     = pc_q - prev_q;

	assign stored_masked = ram_rdata[PATTERN_W-1:0] & mask_q;
	always_comb begin
		any_rot = 1'b0;
		for (int k = 0; k < PITCH_CLASSES; k++) begin
			if (stored_masked == rot_q[k]) any_rot = 1'b1;
		end
	end
	assign entry_ok = ram_rdata[ENTRY_W-1]
		& (ram_rdata[PATTERN_W +: COUNT_W] == count_q) & any_rot;

	assign st.clear_last = clr_q == AW'(TABLE_DEPTH - 1);
	assign st.scan_last  = pc_q == NIBBLE_W'(PITCH_CLASSES - 1);
	assign st.empty      = tally_q < 2'd2;
	assign st.rot_last   = rot_cnt_q == NIBBLE_W'(PITCH_CLASSES - 1);
	assign st.hit        = rd_valid_s1 & entry_ok;
	assign st.search_end = rd_valid_s1 & (rd_idx_s1 == AW'(TABLE_DEPTH - 1));
	assign st.out_free   = ~out_valid_q | ~out_stall;

	assign res_idx_ext = XW'(res_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_set_q <= '0;
			tally_q     <= '0;
			clr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.note_acc) begin
				pitch_set_q <= pitch_set_q | (PITCH_CLASSES'(1) << note_pc);
				if (tally_q != 2'd2) tally_q <= tally_q + 2'd1;
			end
			if (cmd.wrap) begin
				pitch_set_q <= '0;
				tally_q     <= '0;
			end
			if (cmd.search_init) begin
				rd_valid_s1 <= 1'b0;
			end else if (cmd.search_step) begin
				rd_valid_s1 <= ram_re;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			pc_q        <= '0;
			have_prev_q <= 1'b0;
			count_q     <= '0;
			sum_q       <= '0;
			seq_q       <= '0;
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
		end
		if (cmd.scan_step) begin
			pc_q <= pc_q + NIBBLE_W'(1);
			if (cur_bit) begin
				if (have_prev_q) begin
					seq_q   <= set_nibble(seq_q, count_q, gap);
					sum_q   <= sum_q + gap;
					count_q <= count_q + COUNT_W'(1);
				end
				prev_q      <= pc_q;
				have_prev_q <= 1'b1;
			end
		end
		if (cmd.wrap) begin
			rot_cnt_q <= '0;
			if (!st.empty) begin
				seq_q   <= set_nibble(seq_q, count_q, NIBBLE_W'(PITCH_CLASSES) - sum_q);
				count_q <= count_q + COUNT_W'(1);
				mask_q  <= nibble_mask(count_q + COUNT_W'(1));
			end
		end
		if (cmd.rot_step) begin
			rot_cnt_q <= rot_cnt_q + NIBBLE_W'(1);
			rot_q[0]  <= (rot_cnt_q == '0) ? seq_q : rotate_one(rot_q[0], count_q);
			for (int k = 1; k < PITCH_CLASSES; k++) begin
				rot_q[k] <= rot_q[k-1];
			end
		end
		if (cmd.search_init) begin
			addr_q <= '0;
		end else if (cmd.search_step) begin
			if (ram_re) addr_q <= addr_q + (AW+1)'(1);
			rd_idx_s1 <= addr_q[AW-1:0];
			if (st.hit) begin
				res_found_q <= 1'b1;
				res_idx_q   <= rd_idx_s1;
			end
		end
		if (cmd.out_load) begin
			found_q            <= res_found_q;
			match_index_q      <= res_found_q ? res_idx_ext[INDEX_W-1:0] : '0;
			interval_count_q   <= count_q;
			interval_pattern_q <= seq_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign found            = found_q;
	assign match_index      = match_index_q;
	assign interval_count   = interval_count_q;
	assign interval_pattern = interval_pattern_q;

endmodule

>>> rtl/chim_controller.sv
// Controller state machine of the chord interval matcher.
// Sequences table clear, interval scan, rotation setup, search and output.
// Depends on chim_pkg.
module chim_controller (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic                   last,
	input  chim_pkg::chim_status_t st,
	output chim_pkg::chim_cmd_t    cmd
);

	import chim_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRAP,
		ST_ROT,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		cmd             = '0;
		cmd.clear_step  = state_q == ST_CLEAR;
		cmd.note_acc    = accept & (operation == OP_NOTE);
		cmd.write_entry = accept & (operation == OP_WRITE);
		cmd.scan_init   = accept & (operation == OP_NOTE) & last;
		cmd.scan_step   = state_q == ST_SCAN;
		cmd.wrap        = state_q == ST_WRAP;
		cmd.rot_step    = state_q == ST_ROT;
		cmd.search_init = (state_q == ST_ROT) & st.rot_last;
		cmd.search_step = state_q == ST_SEARCH;
		cmd.out_load    = (state_q == ST_DONE) & st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (st.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.scan_init) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (st.scan_last) state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					state_q <= st.empty ? ST_DONE : ST_ROT;
				end
				ST_ROT: begin
					if (st.rot_last) state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (st.hit || st.search_end) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (st.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
